[hw/rtl/clex_pkg.sv]
package clex_pkg;

    // internal widths of the column counters and the mantissa accumulator
    localparam int COL_BITS  = 16;
    localparam int MANT_BITS = 64;

    // widths of the result fields as seen on the port
    localparam int KIND_W = 4;
    localparam int OCOL_W = 16;
    localparam int OMAN_W = 64;
    localparam int EXP_W  = 17;
    localparam int LEN_W  = 16;
    localparam int ERR_W  = 3;

    // result beat packing: col, mantissa, exponent, length, error, zero fill
    localparam int RES_BITS   = OCOL_W + OMAN_W + EXP_W + LEN_W + ERR_W;
    localparam int TDATA_BITS = ((RES_BITS + 7) / 8) * 8;

    // result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [ERR_W-1:0]  err_t;

    localparam kind_t KIND_END    = 4'd0;
    localparam kind_t KIND_NUMBER = 4'd1;
    localparam kind_t KIND_IDENT  = 4'd2;
    localparam kind_t KIND_PLUS   = 4'd3;
    localparam kind_t KIND_MINUS  = 4'd4;
    localparam kind_t KIND_STAR   = 4'd5;
    localparam kind_t KIND_SLASH  = 4'd6;
    localparam kind_t KIND_PCT    = 4'd7;
    localparam kind_t KIND_CARET  = 4'd8;
    localparam kind_t KIND_BANG   = 4'd9;
    localparam kind_t KIND_LPAREN = 4'd10;
    localparam kind_t KIND_RPAREN = 4'd11;
    localparam kind_t KIND_COMMA  = 4'd12;
    localparam kind_t KIND_EQUAL  = 4'd13;
    localparam kind_t KIND_ERROR  = 4'd14;

    localparam err_t ERR_NONE       = 3'd0;
    localparam err_t ERR_UNEXPECTED = 3'd1;
    localparam err_t ERR_EMPTY_PFX  = 3'd2;
    localparam err_t ERR_LONE_DOT   = 3'd3;
    localparam err_t ERR_OVERFLOW   = 3'd4;

    typedef struct packed {
        kind_t                    kind;
        logic [OCOL_W-1:0]        col;
        logic [OMAN_W-1:0]        mant;
        logic signed [EXP_W-1:0]  expo;
        logic [LEN_W-1:0]         len;
        err_t                     err;
        logic                     last;
    } res_t;

    // results of one byte step: up to two beats
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r1;
        res_t       r0;
    } res_pair_t;

endpackage

[hw/rtl/clex_engine.sv]
module clex_engine
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            text_byte,
    input  logic                  end_of_text,
    output clex_pkg::res_pair_t   results
);
    import clex_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_ZERO,
        MODE_PREFIX,
        MODE_DECIMAL,
        MODE_IDENT,
        MODE_ERROR
    } mode_t;

    typedef logic [1:0] radix_t;
    localparam radix_t RADIX_NONE = 2'd0;
    localparam radix_t RADIX_HEX  = 2'd1;
    localparam radix_t RADIX_BIN  = 2'd2;
    localparam radix_t RADIX_OCT  = 2'd3;

    localparam int PW = MANT_BITS + 4;
    localparam logic [PW-1:0] PREFIX_MAX = {5'd0, {(MANT_BITS-1){1'b1}}};
    localparam logic [COL_BITS-1:0] COL_MAX = {COL_BITS{1'b1}};
    localparam logic signed [EXP_W-1:0] EXP_MAX = 17'sd65535;
    localparam logic signed [EXP_W-1:0] EXP_MIN = -17'sd65535;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_hex_letter(input logic [7:0] c);
        return (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic kind_t op_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            "%":     k = KIND_PCT;
            "^":     k = KIND_CARET;
            "!":     k = KIND_BANG;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            ",":     k = KIND_COMMA;
            "=":     k = KIND_EQUAL;
            default: k = KIND_ERROR;
        endcase
        return k;
    endfunction

    function automatic res_t make_res(input kind_t k, input logic [COL_BITS-1:0] col,
                                      input logic [MANT_BITS-1:0] mant,
                                      input logic signed [EXP_W-1:0] expo,
                                      input logic [COL_BITS-1:0] len, input err_t err);
        res_t r;
        r.kind = k;
        r.col  = OCOL_W'(col);
        r.mant = OMAN_W'(mant);
        r.expo = expo;
        r.len  = LEN_W'(len);
        r.err  = err;
        r.last = 1'b0;
        return r;
    endfunction

    mode_t                    mode_reg,  mode_next;
    radix_t                   radix_reg, radix_next;
    logic [MANT_BITS-1:0]     mant_reg,  mant_next;
    logic signed [EXP_W-1:0]  exp_reg,   exp_next;
    logic                     dot_reg,   dot_next;
    logic                     digs_reg,  digs_next;
    logic [COL_BITS-1:0]      start_reg, start_next;
    logic [COL_BITS-1:0]      col_reg,   col_next;
    logic [COL_BITS-1:0]      len_reg,   len_next;

    res_t       res_v [2];
    logic [1:0] cnt_v;

    always_comb
    begin
        logic       do_start;
        logic       brk;
        logic       flush_req;
        logic       fail;
        logic       rdig_ok;
        logic [3:0] rdig;
        logic [PW-1:0] dec_prod;
        logic [PW-1:0] pfx_prod;
        logic [7:0] c;

        mode_next  = mode_reg;
        radix_next = radix_reg;
        mant_next  = mant_reg;
        exp_next   = exp_reg;
        dot_next   = dot_reg;
        digs_next  = digs_reg;
        start_next = start_reg;
        col_next   = col_reg;
        len_next   = len_reg;
        res_v[0]   = '0;
        res_v[1]   = '0;
        cnt_v      = 2'd0;
        do_start   = 1'b0;
        brk        = 1'b0;
        fail       = 1'b0;
        c          = text_byte;

        // digit value in the selected prefixed radix
        case (radix_reg)
            RADIX_HEX: begin
                rdig_ok = is_digit(c) || is_hex_letter(c);
                rdig    = is_digit(c) ? c[3:0] : c[3:0] + 4'd9;
            end
            RADIX_OCT: begin
                rdig_ok = c >= "0" && c <= "7";
                rdig    = c[3:0];
            end
            default: begin
                rdig_ok = c == "0" || c == "1";
                rdig    = c[3:0];
            end
        endcase

        // mantissa * 10 + d, top four bits flag overflow
        dec_prod = ({4'd0, mant_reg} << 3) + ({4'd0, mant_reg} << 1) + PW'(c[3:0]);
        case (radix_reg)
            RADIX_HEX: pfx_prod = ({4'd0, mant_reg} << 4) + PW'(rdig);
            RADIX_OCT: pfx_prod = ({4'd0, mant_reg} << 3) + PW'(rdig);
            default:   pfx_prod = ({4'd0, mant_reg} << 1) + PW'(rdig);
        endcase

        if (step)
        begin
            if (!end_of_text)
            begin
                if (mode_next == MODE_IDLE)
                begin
                    do_start = 1'b1;
                end
                else
                begin
                    if (mode_next == MODE_ZERO)
                    begin
                        if (c == "x" || c == "X")
                        begin
                            mode_next  = MODE_PREFIX;
                            radix_next = RADIX_HEX;
                        end
                        else if (c == "b" || c == "B")
                        begin
                            mode_next  = MODE_PREFIX;
                            radix_next = RADIX_BIN;
                        end
                        else if (c == "o" || c == "O")
                        begin
                            mode_next  = MODE_PREFIX;
                            radix_next = RADIX_OCT;
                        end
                        else
                        begin
                            mode_next = MODE_DECIMAL;
                            digs_next = 1'b1;
                        end
                    end
                    // a zero just turned into a prefix takes no more of this byte
                    if (!(mode_reg == MODE_ZERO && mode_next == MODE_PREFIX))
                    begin
                        case (mode_next)
                            MODE_DECIMAL: begin
                                if (is_digit(c))
                                begin
                                    digs_next = 1'b1;
                                    if (dec_prod[PW-1 -: 4] == 4'd0)
                                    begin
                                        mant_next = dec_prod[MANT_BITS-1:0];
                                        if (dot_reg && exp_reg > EXP_MIN)
                                            exp_next = exp_reg - 17'sd1;
                                    end
                                    else if (!dot_reg && exp_reg < EXP_MAX)
                                    begin
                                        // digit dropped, scale moves up
                                        exp_next = exp_reg + 17'sd1;
                                    end
                                end
                                else if (c == "." && !dot_reg)
                                begin
                                    dot_next = 1'b1;
                                end
                                else
                                begin
                                    brk = 1'b1;
                                end
                            end
                            MODE_PREFIX: begin
                                if (rdig_ok)
                                begin
                                    digs_next = 1'b1;
                                    if (pfx_prod > PREFIX_MAX)
                                    begin
                                        res_v[cnt_v[0]] = make_res(KIND_ERROR, start_reg,
                                            '0, '0, '0, ERR_OVERFLOW);
                                        cnt_v     = cnt_v + 2'd1;
                                        mode_next = MODE_ERROR;
                                    end
                                    else
                                    begin
                                        mant_next = pfx_prod[MANT_BITS-1:0];
                                    end
                                end
                                else
                                begin
                                    brk = 1'b1;
                                end
                            end
                            MODE_IDENT: begin
                                if (is_alpha(c) || is_digit(c) || c == "_")
                                begin
                                    if (len_reg != COL_MAX)
                                        len_next = len_reg + 1'b1;
                                end
                                else
                                begin
                                    brk = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end

            // close the pending token
            flush_req = end_of_text ? (mode_next != MODE_ERROR) : brk;
            if (flush_req)
            begin
                case (mode_next)
                    MODE_ZERO: begin
                        res_v[cnt_v[0]] = make_res(KIND_NUMBER, start_reg, '0, '0, '0,
                                                   ERR_NONE);
                        cnt_v = cnt_v + 2'd1;
                    end
                    MODE_DECIMAL: begin
                        if (!digs_next)
                        begin
                            res_v[cnt_v[0]] = make_res(KIND_ERROR, start_reg, '0, '0, '0,
                                                       ERR_LONE_DOT);
                            fail = 1'b1;
                        end
                        else
                        begin
                            res_v[cnt_v[0]] = make_res(KIND_NUMBER, start_reg, mant_next,
                                                       exp_next, '0, ERR_NONE);
                        end
                        cnt_v = cnt_v + 2'd1;
                    end
                    MODE_PREFIX: begin
                        if (!digs_next)
                        begin
                            res_v[cnt_v[0]] = make_res(KIND_ERROR, start_reg, '0, '0, '0,
                                                       ERR_EMPTY_PFX);
                            fail = 1'b1;
                        end
                        else
                        begin
                            res_v[cnt_v[0]] = make_res(KIND_NUMBER, start_reg, mant_next,
                                                       '0, '0, ERR_NONE);
                        end
                        cnt_v = cnt_v + 2'd1;
                    end
                    MODE_IDENT: begin
                        res_v[cnt_v[0]] = make_res(KIND_IDENT, start_reg, '0, '0, len_next,
                                                   ERR_NONE);
                        cnt_v = cnt_v + 2'd1;
                    end
                    default: begin
                    end
                endcase
                mode_next = fail ? MODE_ERROR : MODE_IDLE;
                do_start  = !end_of_text && !fail;
            end

            // handle the byte as the first of a new token
            if (do_start)
            begin
                mode_next = MODE_IDLE;
                if (!is_space(c))
                begin
                    radix_next = RADIX_NONE;
                    mant_next  = '0;
                    exp_next   = '0;
                    dot_next   = 1'b0;
                    digs_next  = 1'b0;
                    len_next   = '0;
                    start_next = col_reg;
                    if (c == "0")
                    begin
                        mode_next = MODE_ZERO;
                    end
                    else if (is_digit(c))
                    begin
                        mode_next = MODE_DECIMAL;
                        mant_next = MANT_BITS'(c[3:0]);
                        digs_next = 1'b1;
                    end
                    else if (c == ".")
                    begin
                        mode_next = MODE_DECIMAL;
                        dot_next  = 1'b1;
                    end
                    else if (is_alpha(c) || c == "_")
                    begin
                        mode_next = MODE_IDENT;
                        len_next  = COL_BITS'(1);
                    end
                    else if (op_kind(c) != KIND_ERROR)
                    begin
                        res_v[cnt_v[0]] = make_res(op_kind(c), col_reg, '0, '0, '0,
                                                   ERR_NONE);
                        cnt_v = cnt_v + 2'd1;
                    end
                    else
                    begin
                        res_v[cnt_v[0]] = make_res(KIND_ERROR, col_reg, '0, '0, '0,
                                                   ERR_UNEXPECTED);
                        cnt_v     = cnt_v + 2'd1;
                        mode_next = MODE_ERROR;
                    end
                end
            end

            if (end_of_text)
            begin
                res_v[cnt_v[0]] = make_res(KIND_END, col_reg, '0, '0, '0, ERR_NONE);
                cnt_v      = cnt_v + 2'd1;
                mode_next  = MODE_IDLE;
                radix_next = RADIX_NONE;
                mant_next  = '0;
                exp_next   = '0;
                dot_next   = 1'b0;
                digs_next  = 1'b0;
                len_next   = '0;
                start_next = '0;
                col_next   = '0;
            end
            else if (col_reg != COL_MAX)
            begin
                col_next = col_reg + 1'b1;
            end

            if (cnt_v != 2'd0)
                res_v[1'(cnt_v - 2'd1)].last = 1'b1;
        end
    end

    assign results.cnt = cnt_v;
    assign results.r0  = res_v[0];
    assign results.r1  = res_v[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            radix_reg <= RADIX_NONE;
            mant_reg  <= '0;
            exp_reg   <= '0;
            dot_reg   <= 1'b0;
            digs_reg  <= 1'b0;
            start_reg <= '0;
            col_reg   <= '0;
            len_reg   <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            radix_reg <= radix_next;
            mant_reg  <= mant_next;
            exp_reg   <= exp_next;
            dot_reg   <= dot_next;
            digs_reg  <= digs_next;
            start_reg <= start_next;
            col_reg   <= col_next;
            len_reg   <= len_next;
        end
    end

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        step && end_of_text |=> mode_reg == MODE_IDLE && col_reg == '0)
        else $error("end mark did not return the lexer to idle");

    a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
        step && !end_of_text && mode_reg == MODE_ERROR |-> results.cnt == 2'd0)
        else $error("bytes after an error produced a beat");

    a_no_step_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !step |-> results.cnt == 2'd0)
        else $error("beat produced without an accepted byte");

endmodule

[hw/rtl/clex_queue.sv]
module clex_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  clex_pkg::res_pair_t   push,
    input  logic                  pop,
    output logic                  room,
    output logic                  not_empty,
    output clex_pkg::res_t        head
);
    import clex_pkg::*;

    res_t               q_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_reg, wr_next;
    logic [QPTR_W-1:0]  rd_reg, rd_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               do_pop;

    assign not_empty = cnt_reg != '0;
    assign room      = cnt_reg <= QCNT_W'(QDEPTH - 2);
    assign head      = q_reg[rd_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_next  = wr_reg + QPTR_W'(push.cnt);
        rd_next  = rd_reg + QPTR_W'(do_pop);
        cnt_next = cnt_reg + QCNT_W'(push.cnt) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            q_reg[wr_reg] <= push.r0;
        if (push.cnt == 2'd2)
            q_reg[wr_reg + 1'b1] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("result queue count past depth");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd0 |-> room)
        else $error("push into result queue without room");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != '0 && cnt_reg != QCNT_W'(QDEPTH) |->
            QPTR_W'(wr_reg - rd_reg) == QPTR_W'(cnt_reg))
        else $error("queue pointers disagree with count");

endmodule

[hw/rtl/calculator_token_lexer.sv]
// Streaming expression lexer. Each input beat carries one ASCII byte of the
// expression (s_tdata), or an end mark (s_tlast high, byte ignored). Whitespace
// is skipped; operators + - * / % ^ ! ( ) , = come out as single tokens, names
// as column and length, numbers as a 64-bit mantissa with a signed power of
// ten (0x / 0b / 0o prefixes give plain integers with exponent zero). A name or
// number is emitted when the byte after it arrives, so one byte can yield two result
// beats; m_tlast marks the last beat caused by an input beat. After an error
// beat all bytes are dropped until the end mark, which then emits only End;
// otherwise the end mark flushes the pending token and then emits End.
// Throughput: one byte per clock while the result queue has room. Each byte
// accepted is held in the input register, lexed from there, and its result
// beats are registered into a four-entry result queue. The input stalls only
// when the queue cannot take two more beats.
module calculator_token_lexer
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] text_byte
    input  logic                            s_tlast,   // end_of_text
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [clex_pkg::TDATA_BITS-1:0] m_tdata,   // start_column, number_mantissa,
                                                       // decimal_exponent, ident_length,
                                                       // error_code, zero fill
    output logic [clex_pkg::KIND_W-1:0]    m_tuser,   // token_kind
    output logic                            m_tlast    // last_of_run
);
    import clex_pkg::*;

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_eot_reg;

    logic        step;
    logic        room;
    res_pair_t   results;
    res_t        head;

    // a byte is lexed once the queue can take both of its possible beats
    assign step          = in_valid_reg && room;
    assign s_tready      = !in_valid_reg || step;
    assign in_valid_next = s_tvalid && s_tready ? 1'b1 : (step ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
    end

    clex_engine u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .text_byte   (in_byte_reg),
        .end_of_text (in_eot_reg),
        .results     (results)
    );

    clex_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (results),
        .pop       (m_tready),
        .room      (room),
        .not_empty (m_tvalid),
        .head      (head)
    );

    // result beat layout, lowest bits first
    assign m_tdata = TDATA_BITS'({head.err, head.len, head.expo, head.mant, head.col});
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

[tb/calculator_token_lexer_tb.sv]
`timescale 1ns / 1ps

module calculator_token_lexer_tb;

    import clex_pkg::*;

    // stream field offsets inside m_tdata, lowest field first
    localparam int COL_LSB  = 0;
    localparam int MANT_LSB = COL_LSB + OCOL_W;
    localparam int EXP_LSB  = MANT_LSB + OMAN_W;
    localparam int LEN_LSB  = EXP_LSB + EXP_W;
    localparam int ERR_LSB  = LEN_LSB + LEN_W;

    // saturation points of the lexer counters
    localparam int          COL_SAT    = (1 << COL_BITS) - 1;
    localparam int          EXP_LIMIT  = 65535;
    localparam logic [63:0] MANT_ALL   = ~64'd0 >> (64 - MANT_BITS);
    localparam logic [63:0] PREFIX_ALL = MANT_ALL >> 1;

    // radix selector codes for prefixed literals
    localparam logic [1:0] RADIX_NONE = 2'd0;
    localparam logic [1:0] RADIX_HEX  = 2'd1;
    localparam logic [1:0] RADIX_BIN  = 2'd2;
    localparam logic [1:0] RADIX_OCT  = 2'd3;

    localparam int RANDOM_BEATS = 400;
    localparam int LONG_RUN     = 66000;
    localparam int HOLD_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef enum logic [2:0] {
        LX_IDLE,
        LX_ZERO,
        LX_PREFIX,
        LX_DECIMAL,
        LX_IDENT,
        LX_ERROR
    } lex_mode_e;

    // one row of the directed table; hand rows carry a hand-written token
    typedef struct packed {
        logic [7:0]  chr;
        logic        eot;
        logic        hand;
        kind_t       kind;
        logic [15:0] col;
        err_t        err;
    } dir_row_t;

    localparam int N_DIR = 30;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_BITS-1:0] m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;

    calculator_token_lexer u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // lexer state mirrored by the testbench
    lex_mode_e   lx_mode;
    logic [1:0]  lx_radix;
    logic [63:0] lx_mant;
    int          lx_expo;
    bit          lx_dot;
    bit          lx_digits;
    int          lx_start;
    int          lx_col;
    int          lx_len;

    // tokens produced by the current byte, and tokens still owed by the block
    res_t step_out[$];
    res_t tokens_due[$];

    int  fail_count    = 0;
    int  beats_sent    = 0;
    int  beats_checked = 0;
    int  holds_done    = 0;
    int  burst_left    = 0;
    int  cycle_count   = 0;
    bit  no_gaps       = 1'b0;
    bit  hold_req      = 1'b0;

    string OP_CHARS   = "+-*/%^!(),=";
    string NAME_CHARS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string HEX_CHARS  = "0123456789abcdefABCDEF";

    // directed part: every operator, a short mixed line, then three errors
    dir_row_t dir_rows [N_DIR] = '{
        '{"+", 1'b0, 1'b1, KIND_PLUS,   16'd0,  ERR_NONE},
        '{"-", 1'b0, 1'b1, KIND_MINUS,  16'd1,  ERR_NONE},
        '{"*", 1'b0, 1'b1, KIND_STAR,   16'd2,  ERR_NONE},
        '{"/", 1'b0, 1'b1, KIND_SLASH,  16'd3,  ERR_NONE},
        '{"%", 1'b0, 1'b1, KIND_PCT,    16'd4,  ERR_NONE},
        '{"^", 1'b0, 1'b1, KIND_CARET,  16'd5,  ERR_NONE},
        '{"!", 1'b0, 1'b1, KIND_BANG,   16'd6,  ERR_NONE},
        '{"(", 1'b0, 1'b1, KIND_LPAREN, 16'd7,  ERR_NONE},
        '{")", 1'b0, 1'b1, KIND_RPAREN, 16'd8,  ERR_NONE},
        '{",", 1'b0, 1'b1, KIND_COMMA,  16'd9,  ERR_NONE},
        '{"=", 1'b0, 1'b1, KIND_EQUAL,  16'd10, ERR_NONE},
        // identifier, hex literal cut by a dot, decimal flushed by the end mark
        '{"a", 1'b0, 1'b0, KIND_END,    16'd0,  ERR_NONE},
        '{"9", 1'b0, 1'b0, KIND_END,    16'd0,  ERR_NONE},
        '{" ", 1'b0, 1'b0, KIND_END,    16'd0,  ERR_NONE},
        '{"0", 1'b0, 1'b0, KIND_END,    16'd0,  ERR_NONE},
        '{"x", 1'b0, 1'b0, KIND_END,    16'd0,  ERR_NONE},
        '{"F", 1'b0, 1'b0, KIND_END,    16'd0,  ERR_NONE},
        '{".", 1'b0, 1'b0, KIND_END,    16'd0,  ERR_NONE},
        '{"5", 1'b0, 1'b0, KIND_END,    16'd0,  ERR_NONE},
        '{8'h00, 1'b1, 1'b0, KIND_END,  16'd0,  ERR_NONE},
        // lone dot, then a dropped top byte, then end
        '{".", 1'b0, 1'b0, KIND_END,    16'd0,  ERR_NONE},
        '{" ", 1'b0, 1'b1, KIND_ERROR,  16'd0,  ERR_LONE_DOT},
        '{8'hFF, 1'b0, 1'b0, KIND_END,  16'd0,  ERR_NONE},
        '{8'hFF, 1'b1, 1'b1, KIND_END,  16'd3,  ERR_NONE},
        // binary prefix with no digit
        '{"0", 1'b0, 1'b0, KIND_END,    16'd0,  ERR_NONE},
        '{"B", 1'b0, 1'b0, KIND_END,    16'd0,  ERR_NONE},
        '{"2", 1'b0, 1'b1, KIND_ERROR,  16'd0,  ERR_EMPTY_PFX},
        '{8'h00, 1'b1, 1'b1, KIND_END,  16'd3,  ERR_NONE},
        // unexpected byte at column zero
        '{8'h00, 1'b0, 1'b1, KIND_ERROR, 16'd0, ERR_UNEXPECTED},
        '{8'h00, 1'b1, 1'b1, KIND_END,  16'd1,  ERR_NONE}
    };

    // ------------------------------------------------------------------
    // token predictor
    // ------------------------------------------------------------------

    function automatic bit is_blank(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_dec(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    // operator kind, or KIND_ERROR when the byte is no operator
    function automatic kind_t op_token(logic [7:0] c);
        case (c)
            "+":     return KIND_PLUS;
            "-":     return KIND_MINUS;
            "*":     return KIND_STAR;
            "/":     return KIND_SLASH;
            "%":     return KIND_PCT;
            "^":     return KIND_CARET;
            "!":     return KIND_BANG;
            "(":     return KIND_LPAREN;
            ")":     return KIND_RPAREN;
            ",":     return KIND_COMMA;
            "=":     return KIND_EQUAL;
            default: return KIND_ERROR;
        endcase
    endfunction

    // digit value in the current prefixed radix, or -1
    function automatic int radix_value(logic [7:0] c);
        if (lx_radix == RADIX_HEX)
        begin
            if (is_dec(c)) return int'(c - "0");
            if (c >= "a" && c <= "f") return int'(c - "a") + 10;
            if (c >= "A" && c <= "F") return int'(c - "A") + 10;
            return -1;
        end
        if (lx_radix == RADIX_OCT) return (c >= "0" && c <= "7") ? int'(c - "0") : -1;
        return (c == "0" || c == "1") ? int'(c - "0") : -1;
    endfunction

    function automatic void emit_token(kind_t k, int col, logic [63:0] mant, int expo,
                                       int len, err_t err);
        res_t r;
        if (step_out.size() >= 2) return;
        r      = '0;
        r.kind = k;
        r.col  = col[OCOL_W-1:0];
        r.mant = mant;
        r.expo = expo[EXP_W-1:0];
        r.len  = len[LEN_W-1:0];
        r.err  = err;
        step_out.push_back(r);
    endfunction

    function automatic void raise_error(err_t err, int col);
        emit_token(KIND_ERROR, col, 64'd0, 0, 0, err);
        lx_mode = LX_ERROR;
    endfunction

    function automatic void clear_token(int col);
        lx_radix  = RADIX_NONE;
        lx_mant   = 64'd0;
        lx_expo   = 0;
        lx_dot    = 1'b0;
        lx_digits = 1'b0;
        lx_len    = 0;
        lx_start  = col;
    endfunction

    function automatic void lex_reset();
        lx_mode = LX_IDLE;
        clear_token(0);
        lx_col = 0;
    endfunction

    // byte seen while no token is pending
    function automatic void start_byte(logic [7:0] c, int col);
        lx_mode = LX_IDLE;
        if (is_blank(c)) return;
        clear_token(col);
        if (c == "0")
            lx_mode = LX_ZERO;
        else if (is_dec(c))
        begin
            lx_mode   = LX_DECIMAL;
            lx_mant   = 64'(c - "0");
            lx_digits = 1'b1;
        end
        else if (c == ".")
        begin
            lx_mode = LX_DECIMAL;
            lx_dot  = 1'b1;
        end
        else if (is_letter(c) || c == "_")
        begin
            lx_mode = LX_IDENT;
            lx_len  = 1;
        end
        else if (op_token(c) != KIND_ERROR)
            emit_token(op_token(c), col, 64'd0, 0, 0, ERR_NONE);
        else
            raise_error(ERR_UNEXPECTED, col);
    endfunction

    // closes the pending token; 0 when it closed in an error
    function automatic bit flush_token();
        case (lx_mode)
            LX_ZERO:
                emit_token(KIND_NUMBER, lx_start, 64'd0, 0, 0, ERR_NONE);
            LX_DECIMAL:
            begin
                if (!lx_digits)
                begin
                    raise_error(ERR_LONE_DOT, lx_start);
                    return 1'b0;
                end
                emit_token(KIND_NUMBER, lx_start, lx_mant, lx_expo, 0, ERR_NONE);
            end
            LX_PREFIX:
            begin
                if (!lx_digits)
                begin
                    raise_error(ERR_EMPTY_PFX, lx_start);
                    return 1'b0;
                end
                emit_token(KIND_NUMBER, lx_start, lx_mant, 0, 0, ERR_NONE);
            end
            LX_IDENT:
                emit_token(KIND_IDENT, lx_start, 64'd0, 0, lx_len, ERR_NONE);
            default: ;
        endcase
        lx_mode = LX_IDLE;
        return 1'b1;
    endfunction

    // digits past the mantissa width are dropped, scaling the exponent instead
    function automatic void decimal_digit(logic [63:0] d);
        lx_digits = 1'b1;
        if (lx_mant <= (MANT_ALL - d) / 64'd10)
        begin
            lx_mant = lx_mant * 64'd10 + d;
            if (lx_dot && lx_expo > -EXP_LIMIT) lx_expo--;
        end
        else if (!lx_dot && lx_expo < EXP_LIMIT)
            lx_expo++;
    endfunction

    // byte seen while a token is pending or after an error
    function automatic void pending_byte(logic [7:0] c, int col);
        int          d;
        logic [63:0] dv;
        logic [63:0] base;
        if (lx_mode == LX_ZERO)
        begin
            if (c == "x" || c == "X")
            begin
                lx_mode  = LX_PREFIX;
                lx_radix = RADIX_HEX;
                return;
            end
            if (c == "b" || c == "B")
            begin
                lx_mode  = LX_PREFIX;
                lx_radix = RADIX_BIN;
                return;
            end
            if (c == "o" || c == "O")
            begin
                lx_mode  = LX_PREFIX;
                lx_radix = RADIX_OCT;
                return;
            end
            lx_mode   = LX_DECIMAL;
            lx_digits = 1'b1;
        end
        case (lx_mode)
            LX_DECIMAL:
            begin
                if (is_dec(c))
                begin
                    decimal_digit(64'(c - "0"));
                    return;
                end
                if (c == "." && !lx_dot)
                begin
                    lx_dot = 1'b1;
                    return;
                end
            end
            LX_PREFIX:
            begin
                d = radix_value(c);
                if (d >= 0)
                begin
                    dv        = 64'(d);
                    base      = (lx_radix == RADIX_HEX) ? 64'd16 :
                                (lx_radix == RADIX_OCT) ? 64'd8 : 64'd2;
                    lx_digits = 1'b1;
                    if (lx_mant > (PREFIX_ALL - dv) / base)
                    begin
                        raise_error(ERR_OVERFLOW, lx_start);
                        return;
                    end
                    lx_mant = lx_mant * base + dv;
                    return;
                end
            end
            LX_IDENT:
            begin
                if (is_letter(c) || is_dec(c) || c == "_")
                begin
                    if (lx_len < COL_SAT) lx_len++;
                    return;
                end
            end
            default:
                return;
        endcase
        if (flush_token()) start_byte(c, col);
    endfunction

    // one accepted beat: fills step_out with its tokens
    function automatic void lex_step(logic [7:0] c, logic eot);
        int   col;
        res_t r;
        step_out.delete();
        col = lx_col;
        if (eot)
        begin
            if (lx_mode != LX_ERROR) void'(flush_token());
            emit_token(KIND_END, col, 64'd0, 0, 0, ERR_NONE);
            lex_reset();
        end
        else
        begin
            if (lx_mode == LX_IDLE) start_byte(c, col);
            else pending_byte(c, col);
            if (lx_col < COL_SAT) lx_col++;
        end
        if (step_out.size() > 0)
        begin
            r      = step_out.pop_back();
            r.last = 1'b1;
            step_out.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // clock, reset, watchdog
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // result checker: beats compared in order against the owed tokens
    // ------------------------------------------------------------------

    function automatic void check_field(string fname, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, got %0h", fname, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (tokens_due.size() == 0)
            begin
                $error("token beat with nothing owed: kind %0d", m_tuser);
                fail_count++;
            end
            else
            begin
                want = tokens_due.pop_front();
                beats_checked++;
                check_field("token_kind", 64'(want.kind), 64'(m_tuser));
                check_field("start_column", 64'(want.col), 64'(m_tdata[COL_LSB +: OCOL_W]));
                check_field("number_mantissa", want.mant, m_tdata[MANT_LSB +: OMAN_W]);
                check_field("decimal_exponent", 64'(want.expo[EXP_W-1:0]),
                            64'(m_tdata[EXP_LSB +: EXP_W]));
                check_field("ident_length", 64'(want.len), 64'(m_tdata[LEN_LSB +: LEN_W]));
                check_field("error_code", 64'(want.err), 64'(m_tdata[ERR_LSB +: ERR_W]));
                check_field("last_of_run", 64'(want.last), 64'(m_tlast));
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: runs of ready, coin-flip ready and hard stalls, plus a long
    // hold-off on request so the result queue fills and s_tready drops
    // ------------------------------------------------------------------

    initial
    begin
        int mode;
        int run;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            else
            begin
                mode = $urandom_range(0, 2);
                run  = (mode == 2) ? $urandom_range(1, 6) : $urandom_range(10, 60);
                repeat (run)
                begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= 1'($urandom_range(0, 1));
                        default: m_tready <= 1'b0;
                    endcase
                    @(negedge clk);
                    if (hold_req) break;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------

    // idle cycles before the next beat: bursts of back-to-back beats
    function automatic int sender_gap();
        if (no_gaps) return 0;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(1, 24);
        return $urandom_range(1, 8);
    endfunction

    // offer one beat from a falling edge, wait for the handshake, predict
    task automatic send_beat(input logic [7:0] chr, input logic eot,
                             input bit hand = 1'b0, input res_t hand_res = '0);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= chr;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        lex_step(chr, eot);
        if (hand)
            tokens_due.push_back(hand_res);
        else
            foreach (step_out[i]) tokens_due.push_back(step_out[i]);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_blank();
        case ($urandom_range(0, 9))
            0:       send_beat(8'd9, 1'b0);
            1:       send_beat(8'd10, 1'b0);
            2:       send_beat(8'd11, 1'b0);
            3:       send_beat(8'd12, 1'b0);
            4:       send_beat(8'd13, 1'b0);
            default: send_beat(" ", 1'b0);
        endcase
    endtask

    task automatic send_op();
        send_beat(OP_CHARS[$urandom_range(0, OP_CHARS.len() - 1)], 1'b0);
    endtask

    task automatic send_ident();
        int n;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 8);
        // first byte from letters and underscore only
        send_beat(NAME_CHARS[$urandom_range(0, 52)], 1'b0);
        repeat (n - 1) send_beat(NAME_CHARS[$urandom_range(0, NAME_CHARS.len() - 1)], 1'b0);
    endtask

    // decimal with optional dot; some long enough to overflow the mantissa
    task automatic send_decimal();
        int n;
        int frac;
        n    = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 26) : $urandom_range(1, 6);
        frac = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 25) : $urandom_range(0, 5);
        if ($urandom_range(0, 9) == 0)
        begin
            send_beat(".", 1'b0);
            repeat (frac + 1) send_beat(8'("0" + $urandom_range(0, 9)), 1'b0);
        end
        else
        begin
            send_beat(8'("1" + $urandom_range(0, 8)), 1'b0);
            repeat (n - 1) send_beat(8'("0" + $urandom_range(0, 9)), 1'b0);
            if ($urandom_range(0, 2) == 0)
            begin
                send_beat(".", 1'b0);
                repeat (frac) send_beat(8'("0" + $urandom_range(0, 9)), 1'b0);
            end
        end
    endtask

    // 0x / 0b / 0o literals, either case; long ones can run into overflow
    task automatic send_prefixed();
        int  r;
        int  n;
        bit  longer;
        r      = $urandom_range(0, 2);
        longer = ($urandom_range(0, 5) == 0);
        send_beat("0", 1'b0);
        case (r)
            0:
            begin
                send_beat($urandom_range(0, 1) ? "x" : "X", 1'b0);
                n = longer ? $urandom_range(15, 17) : $urandom_range(1, 8);
                repeat (n) send_beat(HEX_CHARS[$urandom_range(0, HEX_CHARS.len() - 1)], 1'b0);
            end
            1:
            begin
                send_beat($urandom_range(0, 1) ? "b" : "B", 1'b0);
                n = longer ? $urandom_range(61, 64) : $urandom_range(1, 12);
                repeat (n) send_beat(8'("0" + $urandom_range(0, 1)), 1'b0);
            end
            default:
            begin
                send_beat($urandom_range(0, 1) ? "o" : "O", 1'b0);
                n = longer ? $urandom_range(20, 23) : $urandom_range(1, 8);
                repeat (n) send_beat(8'("0" + $urandom_range(0, 7)), 1'b0);
            end
        endcase
    endtask

    // junk byte or a malformed literal
    task automatic send_noise();
        case ($urandom_range(0, 4))
            0:
            begin
                send_beat("0", 1'b0);
                send_beat("x", 1'b0);
                send_beat("g", 1'b0);
            end
            1:
            begin
                send_beat("0", 1'b0);
                send_beat("o", 1'b0);
                send_beat("8", 1'b0);
            end
            2:       send_beat(".", 1'b0);
            default: send_beat(8'($urandom_range(0, 255)), 1'b0);
        endcase
    endtask

    // one expression line closed by the end mark
    task automatic send_line(input bit noisy);
        int n;
        int pick;
        n = $urandom_range(1, 10);
        repeat (n)
        begin
            if (noisy && $urandom_range(0, 3) == 0) send_noise();
            pick = $urandom_range(0, 99);
            if (pick < 30)      send_op();
            else if (pick < 50) send_ident();
            else if (pick < 75) send_decimal();
            else if (pick < 92) send_prefixed();
            else
            begin
                // bare zero, or a decimal with leading zeros
                send_beat("0", 1'b0);
                repeat ($urandom_range(0, 2)) send_beat(8'("0" + $urandom_range(0, 7)), 1'b0);
            end
            if ($urandom_range(0, 3) != 0) send_blank();
        end
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_drained();
        while (tokens_due.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    // saturation: identifier length and columns, positive and negative exponent
    task automatic send_long_runs();
        no_gaps = 1'b1;
        repeat (LONG_RUN) send_beat("q", 1'b0);
        send_beat(" ", 1'b0);
        send_beat("1", 1'b0);
        repeat (LONG_RUN) send_beat("9", 1'b0);
        send_beat(" ", 1'b0);
        send_beat(".", 1'b0);
        repeat (LONG_RUN) send_beat("0", 1'b0);
        send_beat("7", 1'b0);
        send_beat("+", 1'b0);
        send_beat(8'h80, 1'b1);
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial
    begin
        dir_row_t row;
        res_t     hand_res;
        int       random_start;
        bit       held;
        bit       paused;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        s_tlast  = 1'b0;
        rst_n    = 1'b0;
        held     = 1'b0;
        paused   = 1'b0;
        lex_reset();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (int i = 0; i < N_DIR; i++)
        begin
            row           = dir_rows[i];
            hand_res      = '0;
            hand_res.kind = row.kind;
            hand_res.col  = row.col;
            hand_res.err  = row.err;
            hand_res.last = 1'b1;
            send_beat(row.chr, row.eot, row.hand, hand_res);
        end

        // random lines, mostly well formed
        random_start = beats_sent;
        while (beats_sent - random_start < RANDOM_BEATS)
        begin
            if (!held && beats_sent - random_start > 120)
            begin
                // receiver holds off while operators keep coming
                held     = 1'b1;
                hold_req = 1'b1;
                repeat (24) send_op();
                send_beat(8'h00, 1'b1);
            end
            if (!paused && beats_sent - random_start > 260)
            begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                wait_drained();
            end
            send_line($urandom_range(0, 6) == 0);
        end

        send_long_runs();

        s_tvalid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d beats (directed table, random lines, saturating runs)", beats_sent);
        $display("checked %0d token beats, %0d long receiver hold-offs", beats_checked,
                 holds_done);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
